>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define CHK_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CHK_ASSERT(lbl, clk, rstn, prop)
`define CHK_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/i2cst_pkg.sv
// Types, constants and mode table for the SCL timing calculator.
package i2cst_pkg;

    localparam int DIV_W     = 40;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int MAX_PRESCALE = 16;
    localparam int P_W       = $clog2(MAX_PRESCALE + 1);

    localparam logic [DIV_W-1:0] PS_PER_SEC = 40'd1000000000000;
    localparam logic [15:0] SYNC_OVH    = 16'd6;
    localparam logic [32:0] LIMIT_LOW   = 33'h100;
    localparam logic [32:0] LIMIT_HIGH  = 33'h100;
    localparam logic [15:0] LIMIT_SETUP = 16'h10;

    localparam logic [1:0] MODE_STD  = 2'd0;
    localparam logic [1:0] MODE_FAST = 2'd1;

    typedef struct packed {
        logic [19:0] max_hz;
        logic [22:0] min_low;
        logic [22:0] min_high;
        logic [22:0] min_setup;
    } mode_par_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCLK,
        S_DOVH,
        S_DBASE,
        S_DPER,
        S_DTOT,
        S_DOVP,
        S_DLO,
        S_DHI,
        S_DSET,
        S_EXTRA,
        S_EVAL,
        S_FIN
    } state_t;

    function automatic mode_par_t mode_par(input logic [1:0] mode);
        mode_par_t mp;
        begin
            mp.max_hz    = 20'd100000;
            mp.min_low   = 23'd4700000;
            mp.min_high  = 23'd4000000;
            mp.min_setup = 23'd250000;
            if (mode == MODE_FAST)
            begin
                mp.max_hz    = 20'd400000;
                mp.min_low   = 23'd1300000;
                mp.min_high  = 23'd600000;
                mp.min_setup = 23'd100000;
            end
            return mp;
        end
    endfunction

endpackage

>>> hw/rtl/i2cst_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module i2cst_div
    import i2cst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic             rem_nz
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       trial;
    logic                 sub_ok;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign sub_ok  = !trial[DIV_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (go && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], sub_ok};
            rem_next = sub_ok ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

>>> hw/rtl/i2c_scl_timing_calculator.sv
// Top level: sequencer that searches prescalers and packs the SCL timing word.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------------
//  request  | start / busy     | clk_hz, speed_mode, target_hz, rise_ns, fall_ns
//  result   | done (strobe)    | valid_res, timing_word
//
// Every division runs on one shared restoring divider. Setup takes two
// divisions, and each prescaler tried takes seven divisions plus the
// S_EXTRA and S_EVAL evaluation states. A rejected request goes from idle
// straight to S_FIN without a division. Reset clears the sequencer and
// the divider; no clearing pass is needed. The receiver cannot stall: done
// is high for one cycle and busy drops in that same cycle.
`include "assert_macros.svh"
module i2c_scl_timing_calculator
    import i2cst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [29:0] clk_hz,
    input  logic [1:0]  speed_mode,
    input  logic [19:0] target_hz,
    input  logic [9:0]  rise_ns,
    input  logic [9:0]  fall_ns,
    output logic        done,
    output logic        valid_res,
    output logic [31:0] timing_word
);

    state_t      state_reg, state_next;
    logic        wait_reg, wait_next;
    logic        done_reg, done_next;
    logic        valid_reg, valid_next;
    logic [31:0] word_reg, word_next;
    logic [29:0] clk_reg, clk_next;
    logic [1:0]  mode_reg, mode_next;
    logic [19:0] target_reg, target_next;
    logic [9:0]  rise_reg, rise_next;
    logic [9:0]  fall_reg, fall_next;
    logic [DIV_W-1:0] d0_reg, d0_next;
    logic [15:0] ovhc_reg, ovhc_next;
    logic [P_W-1:0] p_reg, p_next;
    logic [29:0] base_reg, base_next;
    logic [DIV_W-1:0] per_reg, per_next;
    logic [29:0] tot_reg, tot_next;
    logic [15:0] ovh_reg, ovh_next;
    logic [15:0] lo_reg, lo_next;
    logic [15:0] hi_reg, hi_next;
    logic [15:0] set_reg, set_next;
    logic [32:0] ext_reg, ext_next;

    logic             div_go;
    logic             div_done;
    logic [DIV_W-1:0] div_a;
    logic [DIV_W-1:0] div_b;
    logic [DIV_W-1:0] div_q;
    logic             div_rnz;
    logic [DIV_W:0]   div_cq;
    logic             div_state;

    mode_par_t   mp_in;
    mode_par_t   mp;
    logic [20:0] ovh_ps;
    logic [20:0] set_ps;
    logic [17:0] used_sum;
    logic [32:0] ext_calc;
    logic [32:0] half;
    logic [32:0] lo2;
    logic [32:0] hi2;
    logic        fit;
    logic [7:0]  lo_m1;
    logic [7:0]  hi_m1;
    logic [3:0]  set_m1;
    logic [3:0]  p_m1;

    assign mp_in = mode_par(speed_mode);
    assign mp    = mode_par(mode_reg);

    // Picosecond numerators for overhead and data setup
    assign ovh_ps = 21'(({1'b0, rise_reg} + {1'b0, fall_reg}) * 21'd1000);
    assign set_ps = 21'(rise_reg * 21'd1000) + mp.min_setup[20:0];

    assign div_cq = {1'b0, div_q} + {{DIV_W{1'b0}}, div_rnz};

    // Spare cycles and the split between low and high
    assign used_sum = {2'b0, lo_reg} + {2'b0, hi_reg} + {2'b0, ovh_reg};
    assign ext_calc = {3'b0, tot_reg} - {15'b0, used_sum};
    assign half     = {1'b0, ext_reg[32:1]};
    assign lo2      = {17'b0, lo_reg} + half;
    assign hi2      = {17'b0, hi_reg} + (ext_reg - half);
    assign fit      = (lo2 != '0) && (hi2 != '0) && (set_reg != '0)
                   && (lo2 <= LIMIT_LOW) && (hi2 <= LIMIT_HIGH)
                   && (set_reg <= LIMIT_SETUP);
    assign lo_m1  = 8'(lo2 - 33'd1);
    assign hi_m1  = 8'(hi2 - 33'd1);
    assign set_m1 = 4'(set_reg - 16'd1);
    assign p_m1   = 4'(p_reg - 1'b1);

    // Select divider operands by state
    always_comb
    begin
        div_state = 1'b1;
        div_a     = '0;
        div_b     = '0;
        unique case (state_reg)
            S_DCLK:
            begin
                div_a = PS_PER_SEC;
                div_b = {10'b0, clk_reg};
            end
            S_DOVH:
            begin
                div_a = {19'b0, ovh_ps};
                div_b = d0_reg;
            end
            S_DBASE:
            begin
                div_a = {10'b0, clk_reg};
                div_b = {{(DIV_W-P_W){1'b0}}, p_reg};
            end
            S_DPER:
            begin
                div_a = PS_PER_SEC;
                div_b = {10'b0, base_reg};
            end
            S_DTOT:
            begin
                div_a = {10'b0, base_reg};
                div_b = {20'b0, target_reg};
            end
            S_DOVP:
            begin
                div_a = {24'b0, ovhc_reg};
                div_b = {{(DIV_W-P_W){1'b0}}, p_reg};
            end
            S_DLO:
            begin
                div_a = {17'b0, mp.min_low};
                div_b = per_reg;
            end
            S_DHI:
            begin
                div_a = {17'b0, mp.min_high};
                div_b = per_reg;
            end
            S_DSET:
            begin
                div_a = {19'b0, set_ps};
                div_b = per_reg;
            end
            default:
            begin
                div_state = 1'b0;
            end
        endcase
    end

    assign div_go = div_state && !wait_reg;

    i2cst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    // Next state and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        done_next   = 1'b0;
        valid_next  = valid_reg;
        word_next   = word_reg;
        clk_next    = clk_reg;
        mode_next   = mode_reg;
        target_next = target_reg;
        rise_next   = rise_reg;
        fall_next   = fall_reg;
        d0_next     = d0_reg;
        ovhc_next   = ovhc_reg;
        p_next      = p_reg;
        base_next   = base_reg;
        per_next    = per_reg;
        tot_next    = tot_reg;
        ovh_next    = ovh_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        set_next    = set_reg;
        ext_next    = ext_reg;

        if (div_go)
        begin
            wait_next = 1'b1;
        end
        if (div_done)
        begin
            wait_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    clk_next    = clk_hz;
                    mode_next   = speed_mode;
                    target_next = target_hz;
                    rise_next   = rise_ns;
                    fall_next   = fall_ns;
                    p_next      = P_W'(1);
                    valid_next  = 1'b0;
                    word_next   = '0;
                    if (speed_mode != MODE_STD && speed_mode != MODE_FAST)
                        state_next = S_FIN;
                    else if (target_hz == '0 || target_hz > mp_in.max_hz
                             || clk_hz == '0)
                        state_next = S_FIN;
                    else
                        state_next = S_DCLK;
                end
            end
            S_DCLK:
            begin
                if (div_done)
                begin
                    d0_next    = div_q;
                    state_next = S_DOVH;
                end
            end
            S_DOVH:
            begin
                if (div_done)
                begin
                    ovhc_next  = div_cq[15:0] + SYNC_OVH;
                    state_next = S_DBASE;
                end
            end
            S_DBASE:
            begin
                if (div_done)
                begin
                    base_next = div_q[29:0];
                    if (div_q == '0)
                        state_next = S_FIN;
                    else
                        state_next = S_DPER;
                end
            end
            S_DPER:
            begin
                if (div_done)
                begin
                    per_next   = div_q;
                    state_next = S_DTOT;
                end
            end
            S_DTOT:
            begin
                if (div_done)
                begin
                    tot_next   = div_q[29:0];
                    state_next = S_DOVP;
                end
            end
            S_DOVP:
            begin
                if (div_done)
                begin
                    ovh_next   = div_cq[15:0];
                    state_next = S_DLO;
                end
            end
            S_DLO:
            begin
                if (div_done)
                begin
                    lo_next    = div_cq[15:0];
                    state_next = S_DHI;
                end
            end
            S_DHI:
            begin
                if (div_done)
                begin
                    hi_next    = div_cq[15:0];
                    state_next = S_DSET;
                end
            end
            S_DSET:
            begin
                if (div_done)
                begin
                    set_next   = div_cq[15:0];
                    state_next = S_EXTRA;
                end
            end
            S_EXTRA:
            begin
                // Drop out when the cycle budget is already exceeded
                ext_next = ext_calc;
                if (ext_calc[32])
                    state_next = S_FIN;
                else
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (fit)
                begin
                    valid_next = 1'b1;
                    word_next  = {p_m1, 4'b0, set_m1, 4'b0, hi_m1, lo_m1};
                    state_next = S_FIN;
                end
                else if (p_reg == P_W'(MAX_PRESCALE))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_DBASE;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
            word_reg  <= word_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        clk_reg    <= clk_next;
        mode_reg   <= mode_next;
        target_reg <= target_next;
        rise_reg   <= rise_next;
        fall_reg   <= fall_next;
        d0_reg     <= d0_next;
        ovhc_reg   <= ovhc_next;
        p_reg      <= p_next;
        base_reg   <= base_next;
        per_reg    <= per_next;
        tot_reg    <= tot_next;
        ovh_reg    <= ovh_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        set_reg    <= set_next;
        ext_reg    <= ext_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign valid_res   = valid_reg;
    assign timing_word = word_reg;

    `CHK_ASSERT(a_done_idle, clk, rst_n, done |-> !busy)
    `CHK_ASSERT(a_done_after_work, clk, rst_n, done |-> $past(busy))
    `CHK_ASSERT(a_start_takes, clk, rst_n, (start && !busy) |=> busy)
    `CHK_NEVER(a_invalid_zero, clk, rst_n, done && !valid_res && (timing_word != '0))

endmodule
